/* sv/nlp_pkg.sv */
// types and constants shared by the integer literal parser modules
// no dependencies
`default_nettype none

package nlp_pkg;

  // radix codes, as held in the default radix register and the prefix letters
  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  localparam radix_e RADIX_RESET = RADIX_DEC;

  // parse position inside one literal
  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_HASH   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  localparam int unsigned CHAR_W = 21;

  // character codes
  localparam logic [CHAR_W-1:0] CH_HASH  = 21'h23;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 21'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 21'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 21'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 21'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 21'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 21'h66;
  localparam logic [CHAR_W-1:0] CH_LO_B  = 21'h62;
  localparam logic [CHAR_W-1:0] CH_LO_O  = 21'h6f;
  localparam logic [CHAR_W-1:0] CH_LO_D  = 21'h64;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 21'h78;
  localparam logic [CHAR_W-1:0] CH_LO_E  = 21'h65;
  localparam logic [CHAR_W-1:0] CH_CASE  = 21'h20;
  localparam logic [CHAR_W-1:0] CH_TEN   = 21'd10;

  // classified character, carried from the front to the back
  typedef struct packed {
    logic   last;
    logic   hash;
    logic   sign;
    logic   minus;
    logic   dig_vld;
    logic [3:0] dig;
    logic   pfx_e;
    logic   pfx_rad_vld;
    radix_e pfx_rad;
  } tok_t;

  // queue depth, a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* sv/nlp_front.sv */
// front end: classifies one character into a token
// depends on nlp_pkg
`default_nettype none

module nlp_front (
  input  logic [nlp_pkg::CHAR_W-1:0] char_code_i,
  input  logic                       is_last_i,
  output nlp_pkg::tok_t              tok_o
);

  logic [nlp_pkg::CHAR_W-1:0] lc;

  always_comb begin
    // fold upper-case ascii letters onto lower case
    if (char_code_i >= nlp_pkg::CH_UP_A && char_code_i <= nlp_pkg::CH_UP_Z) begin
      lc = char_code_i | nlp_pkg::CH_CASE;
    end else begin
      lc = char_code_i;
    end

    tok_o         = '0;
    tok_o.last    = is_last_i;
    tok_o.hash    = (char_code_i == nlp_pkg::CH_HASH);
    tok_o.sign    = (char_code_i == nlp_pkg::CH_PLUS) || (char_code_i == nlp_pkg::CH_MINUS);
    tok_o.minus   = (char_code_i == nlp_pkg::CH_MINUS);
    tok_o.pfx_e   = (lc == nlp_pkg::CH_LO_E);
    tok_o.pfx_rad = nlp_pkg::RADIX_BIN;

    if (char_code_i >= nlp_pkg::CH_0 && char_code_i <= nlp_pkg::CH_9) begin
      tok_o.dig_vld = 1'b1;
      tok_o.dig     = 4'(char_code_i - nlp_pkg::CH_0);
    end else if (lc >= nlp_pkg::CH_LO_A && lc <= nlp_pkg::CH_LO_F) begin
      tok_o.dig_vld = 1'b1;
      tok_o.dig     = 4'(lc - nlp_pkg::CH_LO_A + nlp_pkg::CH_TEN);
    end

    priority if (lc == nlp_pkg::CH_LO_B) begin
      tok_o.pfx_rad_vld = 1'b1;
      tok_o.pfx_rad     = nlp_pkg::RADIX_BIN;
    end else if (lc == nlp_pkg::CH_LO_O) begin
      tok_o.pfx_rad_vld = 1'b1;
      tok_o.pfx_rad     = nlp_pkg::RADIX_OCT;
    end else if (lc == nlp_pkg::CH_LO_D) begin
      tok_o.pfx_rad_vld = 1'b1;
      tok_o.pfx_rad     = nlp_pkg::RADIX_DEC;
    end else if (lc == nlp_pkg::CH_LO_X) begin
      tok_o.pfx_rad_vld = 1'b1;
      tok_o.pfx_rad     = nlp_pkg::RADIX_HEX;
    end else begin
      tok_o.pfx_rad_vld = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* sv/nlp_fifo.sv */
// token queue between the front and the back
// depends on nlp_pkg
`default_nettype none

module nlp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nlp_pkg::tok_t     tok_i,
  input  logic              pop_i,
  output nlp_pkg::tok_t     tok_o,
  output nlp_pkg::q_stat_t  stat_o
);

  nlp_pkg::tok_t                   mem_q [nlp_pkg::QDEPTH];
  logic [nlp_pkg::QPTR_W-1:0]      wptr_q, wptr_d;
  logic [nlp_pkg::QPTR_W-1:0]      rptr_q, rptr_d;
  logic [nlp_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  always_comb begin
    stat_o.full  = (cnt_q == nlp_pkg::QCNT_W'(nlp_pkg::QDEPTH));
    stat_o.empty = (cnt_q == '0);
    tok_o        = mem_q[rptr_q];
    // pointers wrap on their own since the depth is a power of two
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= tok_i;
    end
  end

endmodule

`default_nettype wire

/* sv/nlp_back.sv */
// back end: prefix/sign/digit state machine, accumulator and result register
// depends on nlp_pkg
`default_nettype none

module nlp_back #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nlp_pkg::radix_e      default_radix_i,
  input  logic                 tok_valid_i,
  input  nlp_pkg::tok_t        tok_i,
  output logic                 tok_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [63:0]   value_o,
  output logic                 bad_literal_o
);

  nlp_pkg::phase_e         phase_q, phase_d;
  nlp_pkg::radix_e         radix_q, radix_d;
  logic                    radix_seen_q, radix_seen_d;
  logic                    exact_q, exact_d;
  logic                    neg_q, neg_d;
  logic                    err_q, err_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic                    out_vld_q, out_vld_d;
  logic signed [63:0]      value_q, value_d;
  logic                    bad_q, bad_d;

  nlp_pkg::phase_e         phase_n;
  logic                    err_n;
  logic                    err_f;
  logic [VALUE_BITS-1:0]   acc_n;
  nlp_pkg::radix_e         code;
  logic [VALUE_BITS-1:0]   scaled;
  logic [VALUE_BITS-1:0]   acc_step;
  logic                    dig_ok;

  // digit step: acc = radix*acc +/- digit, the sign being known before any digit
  always_comb begin
    code = radix_seen_q ? radix_q : default_radix_i;
    unique case (code)
      nlp_pkg::RADIX_BIN: begin
        scaled = acc_q << 1;
        dig_ok = tok_i.dig_vld && (tok_i.dig < 4'd2);
      end
      nlp_pkg::RADIX_OCT: begin
        scaled = acc_q << 3;
        dig_ok = tok_i.dig_vld && (tok_i.dig < 4'd8);
      end
      nlp_pkg::RADIX_DEC: begin
        scaled = (acc_q << 3) + (acc_q << 1);
        dig_ok = tok_i.dig_vld && (tok_i.dig < 4'd10);
      end
      nlp_pkg::RADIX_HEX: begin
        scaled = acc_q << 4;
        dig_ok = tok_i.dig_vld;
      end
      default: begin
        scaled = acc_q;
        dig_ok = 1'b0;
      end
    endcase
    acc_step = neg_q ? scaled - VALUE_BITS'(tok_i.dig) : scaled + VALUE_BITS'(tok_i.dig);
  end

  always_comb begin
    phase_d      = phase_q;
    radix_d      = radix_q;
    radix_seen_d = radix_seen_q;
    exact_d      = exact_q;
    neg_d        = neg_q;
    err_d        = err_q;
    acc_d        = acc_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    value_d      = value_q;
    bad_d        = bad_q;
    phase_n      = phase_q;
    err_n        = err_q;
    acc_n        = acc_q;
    err_f        = err_q;

    tok_pop_o = tok_valid_i && (!tok_i.last || !out_vld_q || out_ready_i);

    if (tok_pop_o) begin
      if (!err_q) begin
        unique case (phase_q)
          nlp_pkg::PH_HASH: begin
            phase_n = nlp_pkg::PH_PREFIX;
            if (tok_i.pfx_e) begin
              err_n   = exact_q;
              exact_d = 1'b1;
            end else if (tok_i.pfx_rad_vld && !radix_seen_q) begin
              radix_d      = tok_i.pfx_rad;
              radix_seen_d = 1'b1;
            end else begin
              err_n = 1'b1;
            end
          end
          nlp_pkg::PH_PREFIX: begin
            if (tok_i.hash) begin
              phase_n = nlp_pkg::PH_HASH;
            end else if (tok_i.sign) begin
              neg_d   = tok_i.minus;
              phase_n = nlp_pkg::PH_DIGITS;
            end else if (dig_ok) begin
              acc_n   = acc_step;
              phase_n = nlp_pkg::PH_DIGITS;
            end else begin
              err_n = 1'b1;
            end
          end
          nlp_pkg::PH_DIGITS: begin
            if (dig_ok) begin
              acc_n = acc_step;
            end else begin
              err_n = 1'b1;
            end
          end
          default: begin
            err_n = 1'b1;
          end
        endcase
      end

      phase_d = phase_n;
      err_d   = err_n;
      acc_d   = acc_n;

      if (tok_i.last) begin
        // a dangling hash is malformed
        err_f        = err_n || (phase_n == nlp_pkg::PH_HASH);
        out_vld_d    = 1'b1;
        bad_d        = err_f;
        value_d      = err_f ? '0 : 64'(signed'(acc_n));
        phase_d      = nlp_pkg::PH_PREFIX;
        radix_d      = default_radix_i;
        radix_seen_d = 1'b0;
        exact_d      = 1'b0;
        neg_d        = 1'b0;
        err_d        = 1'b0;
        acc_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= nlp_pkg::PH_PREFIX;
      radix_q      <= nlp_pkg::RADIX_RESET;
      radix_seen_q <= 1'b0;
      exact_q      <= 1'b0;
      neg_q        <= 1'b0;
      err_q        <= 1'b0;
      acc_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      radix_q      <= radix_d;
      radix_seen_q <= radix_seen_d;
      exact_q      <= exact_d;
      neg_q        <= neg_d;
      err_q        <= err_d;
      acc_q        <= acc_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    bad_q   <= bad_d;
  end

  assign out_valid_o   = out_vld_q;
  assign value_o       = value_q;
  assign bad_literal_o = bad_q;

endmodule

`default_nettype wire

/* sv/number_literal_parser.sv */
// number_literal_parser: integer literal parser, one character per transaction
// uses nlp_pkg, nlp_front, nlp_fifo and nlp_back
//
// input channel: in_valid_i/in_ready_o carry one code point (char_code_i) and
//   is_last_i, which marks the final character of a literal
// output channel: out_valid_o/out_ready_i carry one result per literal, the
//   signed value (value_o, sign-extended from VALUE_BITS) and bad_literal_o;
//   value_o is zero whenever bad_literal_o is set
// config: cfg_we_i writes cfg_wdata_i into the default radix register
//   (0=binary, 1=octal, 2=decimal, 3=hexadecimal); write it only while idle
// throughput: one character per cycle, set by the single-cycle shift-add
//   accumulate in the back end
// latency: a result appears one cycle after its last character is accepted
//   (the token waits one cycle in the queue, then the back end registers it)
// stall: while out_ready_i is low, characters that are not last keep draining
//   into the parser state; a last character waits at the head of the queue,
//   the two-entry queue then fills and in_ready_o drops
// reset: default radix back to decimal, queue emptied, parser at the start
//   of a literal, no result pending
`default_nettype none

module number_literal_parser #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [20:0]         char_code_i,
  input  logic                is_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [63:0]  value_o,
  output logic                bad_literal_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i
);

  // default radix register
  nlp_pkg::radix_e  default_radix_q, default_radix_d;

  // front to queue
  nlp_pkg::tok_t    front_tok;
  logic             push;

  // queue to back
  nlp_pkg::tok_t    q_tok;
  nlp_pkg::q_stat_t q_stat;
  logic             pop;

  assign default_radix_d = cfg_we_i ? nlp_pkg::radix_e'(cfg_wdata_i) : default_radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_radix_q <= nlp_pkg::RADIX_RESET;
    end else begin
      default_radix_q <= default_radix_d;
    end
  end

  // accept whenever the queue has room
  assign in_ready_o = !q_stat.full;
  assign push       = in_valid_i && in_ready_o;

  nlp_front u_front (
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .tok_o       (front_tok)
  );

  nlp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (front_tok),
    .pop_i  (pop),
    .tok_o  (q_tok),
    .stat_o (q_stat)
  );

  nlp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .default_radix_i (default_radix_q),
    .tok_valid_i     (!q_stat.empty),
    .tok_i           (q_tok),
    .tok_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .value_o         (value_o),
    .bad_literal_o   (bad_literal_o)
  );

  // a malformed literal always reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_literal_o |-> value_o == 64'sd0)
    else $error("bad literal with nonzero value");

  // the queue cannot be full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // a new result needs a token in the queue the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_stat.empty))
    else $error("result without a queued token");

  // a pop never happens from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* dv/tb_number_literal_parser.sv */
// self-checking testbench for number_literal_parser: character stream in, parsed values out
// depends on nlp_pkg and the number_literal_parser rtl
`timescale 1ns / 1ps

module tb_number_literal_parser;
  import nlp_pkg::*;

  localparam int unsigned VALUE_BITS = 64;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
  // highest legal code point, and the upper-case end of the hex letters
  localparam logic [CHAR_W-1:0] CHAR_MAX = 21'h10ffff;
  localparam logic [CHAR_W-1:0] CH_UP_F = CH_UP_A + 21'd5;
  // cycles to let the token queue and result register drain
  localparam int unsigned LAT_WAIT = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WD_LIMIT = 2000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               bad;
  } literal_result_t;

  // predictor copy of the per-literal parse state
  typedef struct {
    phase_e      phase;
    radix_e      radix;
    logic        exact_seen;
    logic        radix_seen;
    logic        negative;
    logic        err;
    logic [63:0] acc;
  } literal_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [20:0] char_code_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [63:0] value_o;
  logic bad_literal_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = RADIX_RESET;

  char_item_t      char_q[$];     // characters waiting to be sent
  literal_result_t parsed_q[$];   // parse results still to come out
  literal_state_t  lit;
  radix_e          cfg_radix = RADIX_RESET;
  int unsigned     items_pushed = 0;
  int unsigned     mismatches = 0;
  bit              gaps_on = 1'b1;
  bit              hold_req = 1'b0;

  number_literal_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .bad_literal_o(bad_literal_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic literal_state_t fresh_literal();
    literal_state_t s;
    s.phase = PH_PREFIX;
    s.radix = cfg_radix;
    s.exact_seen = 1'b0;
    s.radix_seen = 1'b0;
    s.negative = 1'b0;
    s.err = 1'b0;
    s.acc = '0;
    return s;
  endfunction

  function automatic logic [63:0] radix_base(input radix_e r);
    case (r)
      RADIX_BIN: return 64'd2;
      RADIX_OCT: return 64'd8;
      RADIX_DEC: return 64'd10;
      default:   return 64'd16;
    endcase
  endfunction

  // one digit character: must be a hex digit below the radix in force
  task automatic take_digit(input logic [CHAR_W-1:0] c);
    logic [63:0] base;
    int d;
    // without a radix prefix the live register value applies to each digit
    base = radix_base(lit.radix_seen ? lit.radix : cfg_radix);
    if (c >= CH_0 && c <= CH_9) d = int'(c - CH_0);
    else if (c >= CH_LO_A && c <= CH_LO_F) d = int'(c - CH_LO_A) + 10;
    else if (c >= CH_UP_A && c <= CH_UP_F) d = int'(c - CH_UP_A) + 10;
    else d = -1;
    if (d < 0 || 64'(d) >= base) begin
      lit.err = 1'b1;
    end else begin
      lit.acc = (base * lit.acc + 64'(d)) & VALUE_MASK;
      lit.phase = PH_DIGITS;
    end
  endtask

  // advance the parse by one accepted character, queue a result on the last one
  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [CHAR_W-1:0] lc;
    logic [63:0] v;
    literal_result_t res;
    // an error is sticky: later characters are skipped until the last one
    if (!lit.err) begin
      if (lit.phase == PH_HASH) begin
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CH_CASE : c;
        if (lc == CH_LO_E) begin
          if (lit.exact_seen) lit.err = 1'b1;
          lit.exact_seen = 1'b1;
        end else if (!lit.radix_seen && (lc == CH_LO_B || lc == CH_LO_O ||
                                         lc == CH_LO_D || lc == CH_LO_X)) begin
          lit.radix = (lc == CH_LO_B) ? RADIX_BIN :
                      (lc == CH_LO_O) ? RADIX_OCT :
                      (lc == CH_LO_D) ? RADIX_DEC : RADIX_HEX;
          lit.radix_seen = 1'b1;
        end else begin
          // second radix prefix or any other character after the hash
          lit.err = 1'b1;
        end
        lit.phase = PH_PREFIX;
      end else if (lit.phase == PH_PREFIX) begin
        if (c == CH_HASH) begin
          lit.phase = PH_HASH;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          lit.negative = (c == CH_MINUS);
          lit.phase = PH_DIGITS;
        end else begin
          take_digit(c);
        end
      end else begin
        // signs after the prefix position land here and fail as non-digits
        take_digit(c);
      end
    end
    if (last) begin
      // a dangling hash at the end is malformed
      if (lit.phase == PH_HASH) lit.err = 1'b1;
      if (lit.err) begin
        res.value = '0;
        res.bad = 1'b1;
      end else begin
        v = lit.negative ? (64'd0 - lit.acc) : lit.acc;
        v &= VALUE_MASK;
        if (VALUE_BITS < 64 && v[VALUE_BITS-1]) v |= ~VALUE_MASK;
        res.value = v;
        res.bad = 1'b0;
      end
      parsed_q.push_back(res);
      lit = fresh_literal();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // gap length: mostly none or short, now and then long
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // lower-case letters randomly turned upper-case
  function automatic logic [CHAR_W-1:0] pick_case(input logic [CHAR_W-1:0] c);
    if (c >= CH_LO_A && c <= CH_LO_A + 21'd25 && $urandom_range(1) == 1) return c - CH_CASE;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
    if (d < 10) return CH_0 + CHAR_W'(d);
    return pick_case(CH_LO_A + CHAR_W'(d - 10));
  endfunction

  // characters that break or confuse a literal
  function automatic logic [CHAR_W-1:0] noise_char();
    case ($urandom_range(9))
      0: return CH_HASH;
      1: return ($urandom_range(1) == 1) ? CH_PLUS : CH_MINUS;
      2: return digit_char($urandom_range(15));
      3: begin
        case ($urandom_range(4))
          0: return pick_case(CH_LO_B);
          1: return pick_case(CH_LO_O);
          2: return pick_case(CH_LO_D);
          3: return pick_case(CH_LO_X);
          default: return pick_case(CH_LO_E);
        endcase
      end
      4: return pick_case(CH_LO_A + CHAR_W'($urandom_range(25)));
      5: return CHAR_W'($urandom_range(127));
      9: return CH_0 + CHAR_W'($urandom_range(9));
      default: return CHAR_W'($urandom_range(CHAR_MAX));
    endcase
  endfunction

  task automatic push_code(input logic [CHAR_W-1:0] code, input logic last);
    char_item_t it;
    it.code = code;
    it.last = last;
    char_q.push_back(it);
    items_pushed++;
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      push_code(CHAR_W'(s[i]), last && (i == s.len() - 1));
    end
  endtask

  // one random literal: mostly well formed, the rest noise
  task automatic gen_literal();
    logic [CHAR_W-1:0] body[$];
    logic [2:0] pfx;
    radix_e eff;
    int unsigned n;
    eff = cfg_radix;
    if ($urandom_range(99) < 80) begin
      pfx = 3'($urandom_range(7));
      // exactness and radix prefixes in either order
      if (pfx[0] && pfx[2]) begin
        body.push_back(CH_HASH);
        body.push_back(pick_case(CH_LO_E));
      end
      if (pfx[1]) begin
        eff = radix_e'($urandom_range(3));
        body.push_back(CH_HASH);
        case (eff)
          RADIX_BIN: body.push_back(pick_case(CH_LO_B));
          RADIX_OCT: body.push_back(pick_case(CH_LO_O));
          RADIX_DEC: body.push_back(pick_case(CH_LO_D));
          default:   body.push_back(pick_case(CH_LO_X));
        endcase
      end
      if (pfx[0] && !pfx[2]) begin
        body.push_back(CH_HASH);
        body.push_back(pick_case(CH_LO_E));
      end
      case ($urandom_range(3))
        1: body.push_back(CH_PLUS);
        2: body.push_back(CH_MINUS);
        default: ;
      endcase
      // long digit runs can wrap the accumulator
      n = ($urandom_range(99) < 10) ? $urandom_range(40, 17) : $urandom_range(6);
      repeat (n) body.push_back(digit_char($urandom_range(int'(radix_base(eff)) - 1)));
      if (body.size() == 0) body.push_back(digit_char(0));
      // a broken sequence now and then
      if ($urandom_range(9) == 0) body.insert($urandom_range(body.size() - 1), noise_char());
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) body.push_back(noise_char());
    end
    foreach (body[i]) push_code(body[i], i == body.size() - 1);
  endtask

  // sender quiet, all results out, pipeline drained
  task automatic wait_idle();
    do @(negedge clk_i); while (char_q.size() != 0 || in_valid_i || parsed_q.size() != 0);
    repeat (LAT_WAIT) @(negedge clk_i);
  endtask

  task automatic write_radix(input radix_e r);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    cfg_radix = r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one character transaction at a time from char_q
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    char_item_t nxt;
    int unsigned send_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_code_i <= '0;
      is_last_i <= 1'b0;
      send_gap = 0;
    end else begin
      // predict as soon as the block takes the character
      if (in_valid_i && in_ready_o) parse_char(char_code_i, is_last_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (char_q.size() > 0) begin
          nxt = char_q.pop_front();
          in_valid_i <= 1'b1;
          char_code_i <= nxt.code;
          is_last_i <= nxt.last;
          send_gap = gaps_on ? rand_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and receiver: checks each result transaction, stalls at random
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    literal_result_t want;
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    bit hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt = 0;
      hold_cnt = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value %0d bad %0b", value_o, bad_literal_o);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          if (value_o !== want.value || bad_literal_o !== want.bad) begin
            if (mismatches < 10)
              $display("mismatch: expected value %0d (%h) bad %0b, got value %0d (%h) bad %0b",
                       want.value, want.value, want.bad, value_o, value_o, bad_literal_o);
            mismatches++;
          end
        end
      end
      // one long hold-off so that the input side backs up
      if (hold_req && !hold_done) begin
        hold_cnt = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_cnt = gaps_on ? rand_gap() : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transaction on either side
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WD_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    radix_e r;
    int unsigned start_cnt;
    int unsigned quota;
    lit = fresh_literal();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, at the reset radix (decimal)
    push_text("#", 1'b1);       // hash as the last character
    push_text("-", 1'b1);       // sign only, no digits
    push_text("#Xf", 1'b1);     // hex prefix in upper case
    push_text("#b2", 1'b1);     // digit equal to the radix
    push_text("#o#d", 1'b1);    // second radix prefix
    push_text("#e#e", 1'b1);    // second exactness prefix
    push_text("#q", 1'b1);      // unknown prefix letter
    push_text("+-1", 1'b1);     // two signs
    push_text("1-", 1'b1);      // sign after a digit
    push_code('0, 1'b1);        // lowest code point
    push_code(CHAR_MAX, 1'b1);  // highest code point, non-ascii

    // radix register changed in the middle of a literal without a prefix
    push_text("12", 1'b0);
    wait_idle();
    write_radix(RADIX_HEX);
    push_text("3f", 1'b1);

    // random phases, each at its own default radix
    for (int ph = 0; ph < 8; ph++) begin
      // sender waits here until every result has arrived
      wait_idle();
      case (ph)
        0: r = RADIX_BIN;
        1: r = RADIX_HEX;
        2: r = RADIX_OCT;
        3: r = RADIX_DEC;
        default: r = radix_e'($urandom_range(3));
      endcase
      write_radix(r);
      // one phase without any idling on either side
      gaps_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      quota = (ph == 1) ? 250 : 100;
      start_cnt = items_pushed;
      while (items_pushed - start_cnt < quota) gen_literal();
    end

    wait_idle();
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
